// File: rtl/tcpop_pkg.sv
// Package for the TCP options area parser: transfer payload types and constants.
// No dependencies; imported by every module of the block.
package tcpop_pkg;

    localparam int MAX_ENTRIES    = 31;
    localparam int MAX_AREA_BYTES = 40;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    // entry codes
    localparam logic [2:0] ENT_NOP  = 3'd0;
    localparam logic [2:0] ENT_MSS  = 3'd1;
    localparam logic [2:0] ENT_WS   = 3'd2;
    localparam logic [2:0] ENT_SACK = 3'd3;
    localparam logic [2:0] ENT_TS   = 3'd4;

    // option kinds
    localparam logic [7:0] KIND_EOL  = 8'd0;
    localparam logic [7:0] KIND_NOP  = 8'd1;
    localparam logic [7:0] KIND_MSS  = 8'd2;
    localparam logic [7:0] KIND_WS   = 8'd3;
    localparam logic [7:0] KIND_SACK = 8'd4;
    localparam logic [7:0] KIND_TS   = 8'd8;

    typedef struct packed {
        logic       start_req;
        logic [5:0] area_length;
        logic [7:0] option_byte;
    } in_t;

    typedef struct packed {
        logic        is_summary;
        logic [2:0]  entry_code;
        logic [15:0] mss;
        logic        mss_present;
        logic [7:0]  wscale_shift;
        logic        wscale_present;
        logic        sack_permitted;
        logic        timestamp_present;
        logic        timestamp_nonzero;
        logic [4:0]  entry_count;
    } res_t;

    // results raised by one input transfer
    typedef struct packed {
        logic ent_valid;
        logic sum_valid;
    } push_t;

endpackage

// File: rtl/tcpop_parser.sv
// Option parse state and per-byte next-state logic of the TCP options parser.
// Depends on tcpop_pkg; gives at most an entry and a summary per byte.
module tcpop_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,
    input  tcpop_pkg::in_t  in_item,
    output tcpop_pkg::push_t push,
    output tcpop_pkg::res_t ent_res,
    output tcpop_pkg::res_t sum_res
);
    import tcpop_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_KIND = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_BODY = 3'd3;
    localparam logic [2:0] PH_STOP = 3'd4;

    localparam int F_MSS  = 0;
    localparam int F_WS   = 1;
    localparam int F_SACK = 2;
    localparam int F_TS   = 3;
    localparam int F_TSNZ = 4;

    logic [5:0]  bytes_left_reg, bytes_left_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  kind_reg, kind_next;
    logic [5:0]  len_reg, len_next;
    logic [5:0]  bidx_reg, bidx_next;
    logic [31:0] vs_reg, vs_next;
    logic [15:0] mss_reg, mss_next;
    logic [7:0]  scale_reg, scale_next;
    logic [4:0]  flags_reg, flags_next;
    logic [4:0]  ents_reg, ents_next;

    logic [5:0]  alen_sat;
    logic [7:0]  b;
    logic        fin;
    logic        want_ent;
    logic [2:0]  want_code;
    logic [2:0]  got;
    logic        ent_v;
    logic        sum_v;

    assign b        = in_item.option_byte;
    assign alen_sat = (in_item.area_length > 6'(MAX_AREA_BYTES)) ?
                      6'(MAX_AREA_BYTES) : in_item.area_length;

    always_comb begin
        bytes_left_next = bytes_left_reg;
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        len_next        = len_reg;
        bidx_next       = bidx_reg;
        vs_next         = vs_reg;
        mss_next        = mss_reg;
        scale_next      = scale_reg;
        flags_next      = flags_reg;
        ents_next       = ents_reg;
        fin             = 1'b0;
        want_ent        = 1'b0;
        want_code       = ENT_NOP;
        got             = 3'd0;
        ent_v           = 1'b0;
        sum_v           = 1'b0;

        if (in_item.start_req) begin
            bytes_left_next = alen_sat;
            phase_next      = (alen_sat == 6'd0) ? PH_IDLE : PH_KIND;
            kind_next       = '0;
            len_next        = '0;
            bidx_next       = '0;
            vs_next         = '0;
            mss_next        = '0;
            scale_next      = '0;
            flags_next      = '0;
            ents_next       = '0;
        end

        if (in_item.start_req && alen_sat == 6'd0) begin
            // empty area: summary at once
            sum_v = 1'b1;
        end else if (bytes_left_next != 6'd0 && phase_next != PH_IDLE
                     && phase_next <= PH_STOP) begin
            unique case (phase_next)
                PH_KIND: begin
                    if (b == KIND_EOL) begin
                        phase_next = PH_STOP;
                    end else if (b == KIND_NOP) begin
                        want_ent  = 1'b1;
                        want_code = ENT_NOP;
                    end else if (bytes_left_next <= 6'd1) begin
                        phase_next = PH_STOP;
                    end else begin
                        kind_next  = b;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (b < 8'd2 || {1'b0, b} > ({3'b0, bytes_left_next} + 9'd1)) begin
                        phase_next = PH_STOP;
                    end else begin
                        len_next  = b[5:0];
                        bidx_next = '0;
                        vs_next   = '0;
                        if (b == 8'd2) fin = 1'b1;
                        else           phase_next = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (bidx_next < 6'd4) vs_next = {vs_next[23:0], b};
                    bidx_next = bidx_next + 6'd1;
                    if ((7'(bidx_next) + 7'd2) >= {1'b0, len_next}) fin = 1'b1;
                end
                default: begin
                end
            endcase

            if (fin) begin
                got = (len_next > 6'd6) ? 3'd4 : 3'(len_next - 6'd2);
                case (kind_next)
                    KIND_MSS: begin
                        if (len_next >= 6'd4) begin
                            case (got)
                                3'd2:    mss_next = vs_next[15:0];
                                3'd3:    mss_next = vs_next[23:8];
                                default: mss_next = vs_next[31:16];
                            endcase
                            flags_next[F_MSS] = 1'b1;
                            want_ent  = 1'b1;
                            want_code = ENT_MSS;
                        end
                    end
                    KIND_WS: begin
                        if (len_next >= 6'd3) begin
                            case (got)
                                3'd1:    scale_next = vs_next[7:0];
                                3'd2:    scale_next = vs_next[15:8];
                                3'd3:    scale_next = vs_next[23:16];
                                default: scale_next = vs_next[31:24];
                            endcase
                            flags_next[F_WS] = 1'b1;
                            want_ent  = 1'b1;
                            want_code = ENT_WS;
                        end
                    end
                    KIND_SACK: begin
                        flags_next[F_SACK] = 1'b1;
                        want_ent  = 1'b1;
                        want_code = ENT_SACK;
                    end
                    KIND_TS: begin
                        flags_next[F_TS]   = 1'b1;
                        flags_next[F_TSNZ] = (len_next >= 6'd10) && (vs_next != 32'd0);
                        want_ent  = 1'b1;
                        want_code = ENT_TS;
                    end
                    default: begin
                    end
                endcase
                phase_next = PH_KIND;
            end

            if (want_ent && ents_next < 5'(MAX_ENTRIES)) begin
                ents_next = ents_next + 5'd1;
                ent_v     = 1'b1;
            end

            bytes_left_next = bytes_left_next - 6'd1;
            if (bytes_left_next == 6'd0) begin
                sum_v      = 1'b1;
                phase_next = PH_IDLE;
            end
        end
    end

    always_comb begin
        ent_res             = '0;
        ent_res.entry_code  = want_code;
        ent_res.entry_count = ents_next;

        sum_res                   = '0;
        sum_res.is_summary        = 1'b1;
        sum_res.mss               = flags_next[F_MSS] ? mss_next : 16'd0;
        sum_res.mss_present       = flags_next[F_MSS];
        sum_res.wscale_shift      = flags_next[F_WS] ? scale_next : 8'd0;
        sum_res.wscale_present    = flags_next[F_WS];
        sum_res.sack_permitted    = flags_next[F_SACK];
        sum_res.timestamp_present = flags_next[F_TS];
        sum_res.timestamp_nonzero = flags_next[F_TSNZ];
        sum_res.entry_count       = ents_next;
    end

    assign push.ent_valid = step_en & ent_v;
    assign push.sum_valid = step_en & sum_v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            phase_reg      <= PH_IDLE;
            kind_reg       <= '0;
            len_reg        <= '0;
            bidx_reg       <= '0;
            vs_reg         <= '0;
            mss_reg        <= '0;
            scale_reg      <= '0;
            flags_reg      <= '0;
            ents_reg       <= '0;
        end else if (step_en) begin
            bytes_left_reg <= bytes_left_next;
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            len_reg        <= len_next;
            bidx_reg       <= bidx_next;
            vs_reg         <= vs_next;
            mss_reg        <= mss_next;
            scale_reg      <= scale_next;
            flags_reg      <= flags_next;
            ents_reg       <= ents_next;
        end
    end

`ifndef NO_ASSERTIONS
    // an open area always has bytes outstanding
    a_open_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_IDLE |-> bytes_left_reg != 6'd0)
        else $error("parse phase open with no bytes left");

    // a summary closes the area
    a_summary_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        push.sum_valid |=> (phase_reg == PH_IDLE && bytes_left_reg == 6'd0))
        else $error("area still open after summary");

    a_entry_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        push.ent_valid |-> ent_res.entry_count <= 5'(MAX_ENTRIES)
                           && ent_res.entry_count != 5'd0)
        else $error("entry count out of range");
`endif

endmodule

// File: rtl/tcpop_fifo.sv
// Result queue of the TCP options parser: takes up to two results a cycle, gives one while m_ready is high.
// Depends on tcpop_pkg for the result type and depth.
module tcpop_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  tcpop_pkg::push_t push,
    input  tcpop_pkg::res_t  ent_res,
    input  tcpop_pkg::res_t  sum_res,
    output logic             has_room,
    output logic             m_valid,
    input  logic             m_ready,
    output tcpop_pkg::res_t  m_data
);
    import tcpop_pkg::*;

    res_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    logic                  w0_valid;
    logic                  w1_valid;
    res_t                  w0_data;
    logic                  pop;
    logic [FIFO_CNT_W-1:0] n_push;

    assign w0_valid = push.ent_valid | push.sum_valid;
    assign w1_valid = push.ent_valid & push.sum_valid;
    assign w0_data  = push.ent_valid ? ent_res : sum_res;
    assign n_push   = FIFO_CNT_W'(w0_valid) + FIFO_CNT_W'(w1_valid);

    assign m_valid  = (count_reg != '0);
    assign m_data   = mem[rd_ptr_reg];
    assign pop      = m_valid & m_ready;
    assign has_room = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign count_next  = count_reg + n_push - FIFO_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (w0_valid) mem[wr_ptr_reg] <= w0_data;
        if (w1_valid) mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= sum_res;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        w0_valid |-> count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2))
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    // head result held while the receiver stalls
    a_head_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed before its transfer");
`endif

endmodule

// File: rtl/tcp_option_parser_core.sv
// TCP options area parser, top level: input/output handshakes and result queue.
// Depends on tcpop_pkg, tcpop_parser and tcpop_fifo.
//
// Usage:
//   s_* channel: one options byte per transfer. start_req marks the first byte of
//     an area and carries area_length (saturated to 40; 0 gives an empty summary).
//   m_* channel: results. Each recognised option gives an entry transfer as its
//     last byte is taken (up to 31 per area); the last byte of the area is
//     followed by a summary transfer with MSS, window scale and flags.
//   Throughput: one byte per cycle while s_ready is high. Parsing is a single pass
//     of logic between the parse state registers and a four-entry result queue.
//   Output: a byte transfer that raises a result writes it into the queue, and m_valid is high the cycle after.
//   Stall: s_ready drops while the queue has fewer than two free slots, since
//     one byte may raise both an entry and the summary. The queue drains one
//     result a cycle, so even with m_ready held high the input pauses when
//     such double-result bytes come close together (e.g. one-byte areas).
//   Reset: aresetn (synchronous, active low) closes any open area and empties
//     the queue; bytes without start_req outside an area are dropped.
module tcp_option_parser_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tcpop_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output tcpop_pkg::res_t m_data
);
    import tcpop_pkg::*;

    logic  s_xfer;
    logic  has_room;
    push_t push;
    res_t  ent_res;
    res_t  sum_res;

    // input transfer advances the parse state
    assign s_ready = has_room;
    assign s_xfer  = s_valid & s_ready;

    tcpop_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (s_xfer),
        .in_item (s_data),
        .push    (push),
        .ent_res (ent_res),
        .sum_res (sum_res)
    );

    // entry first, summary second, in queue order
    tcpop_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .ent_res  (ent_res),
        .sum_res  (sum_res),
        .has_room (has_room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef NO_ASSERTIONS
    // results only appear after an input transfer
    a_push_needs_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.ent_valid || push.sum_valid) |-> s_xfer)
        else $error("result raised without input transfer");

    a_valid_after_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.ent_valid || push.sum_valid) |=> m_valid)
        else $error("queued result not offered");

    a_start_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_data.start_req && s_data.area_length == 6'd0) |-> push.sum_valid
            && !push.ent_valid)
        else $error("empty area did not give a lone summary");
`endif

endmodule
